/* rtl/core/tbss_pkg.sv */
package tbss_pkg;

  // Side limits; every nonzero block side is a power of two, carried as an exponent.
  localparam int MAX_SIDE    = 2048;
  localparam int COMPAT_SIDE = 256;

  localparam int IN_W   = 15;
  localparam int SIDE_W = 12;
  localparam int EXP_W  = 4;
  localparam int AREA_W = 23;
  localparam int LOD_W  = 4;
  localparam int ASP_W  = 3;

  localparam logic [EXP_W-1:0] MAX_LOG2    = EXP_W'($clog2(MAX_SIDE));
  localparam logic [EXP_W-1:0] COMPAT_LOG2 = EXP_W'($clog2(COMPAT_SIDE));

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    MODE_UP     = 2'd0,
    MODE_DOWN   = 2'd1,
    MODE_COMPAT = 2'd2,
    MODE_DOWN_X = 2'd3
  } size_mode_t;

  localparam logic REG_SIZE_MODE = 1'b0;

  typedef struct packed {
    logic [IN_W-1:0] image_width;
    logic [IN_W-1:0] image_height;
  } in_item_t;

  typedef struct packed {
    logic [SIDE_W-1:0] block_width;
    logic [SIDE_W-1:0] block_height;
    logic [LOD_W-1:0]  lod_log2;
    logic [ASP_W-1:0]  aspect_index;
    logic [AREA_W-1:0] block_area;
    logic              too_small;
  } out_item_t;

  // Position of the highest set bit; zero for an input of zero or one.
  function automatic logic [EXP_W-1:0] floor_log2(input logic [IN_W-1:0] v);
    logic [EXP_W-1:0] n;
    n = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (v[i]) begin
        n = EXP_W'(i);
      end
    end
    return n;
  endfunction

endpackage

/* rtl/core/texture_block_size_select.sv */
// Channel   Ports                         Beat
// input     in_valid, in_stall, in_data   image width and height
// output    out_valid, out_stall, out_data block sides, lod, aspect, area, flag
// config    psel..pready (APB-style)      size_mode at byte address 0
//
// Four register stages: leading-one detect, rounding, aspect limit, decode
// and area. One beat enters every cycle while in_stall is low.
// Reset clears the stage valid bits and sets size_mode to round-up.
// A stall on the output holds the last stage; empty stages upstream keep
// filling, and in_stall rises only when all four stages hold a beat and
// the output is stalled.
module texture_block_size_select (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tbss_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tbss_pkg::out_item_t             out_data,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbss_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tbss_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tbss_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import tbss_pkg::*;

  logic [1:0] size_mode_r;
  logic       reg_sel;

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  // stage 1
  logic [EXP_W-1:0] w_fl, h_fl, w_fl_r, h_fl_r;
  logic             w_p2, h_p2, w_p2_r, h_p2_r;
  logic             w_z, h_z, w_z_r, h_z_r;
  logic             down, down_r;
  logic [EXP_W-1:0] lim, lim_r;

  // stage 2
  logic [EXP_W-1:0] w_cl, h_cl;
  logic [EXP_W-1:0] ew2, eh2, ew2_r, eh2_r;
  logic             zw2, zh2, zw2_r, zh2_r;
  logic             small2, small2_r;

  // stage 3
  logic             w_ge;
  logic [EXP_W-1:0] emx, emn, diff;
  logic             zmx, zmn, clip;
  logic [EXP_W-1:0] ew3, eh3, ew3_r, eh3_r;
  logic             zw3, zh3, zw3_r, zh3_r;
  logic [EXP_W-1:0] e_cut;
  logic             z_cut;
  logic [ASP_W-1:0] asp, asp_r;
  logic [LOD_W-1:0] lod_r;
  logic             small3_r;

  // stage 4
  out_item_t        res, out_r;

  // configuration
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_SIZE_MODE);
  assign prdata  = reg_sel ? {{(CFG_DATA_W-2){1'b0}}, size_mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_mode_r <= MODE_UP;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      size_mode_r <= pwdata[1:0];
    end
  end

  // flow control: a stage advances when it is empty or its successor moves
  assign adv4     = !v4_r || !out_stall;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // stage 1: leading-one detect and mode decision
  always_comb begin
    w_fl = floor_log2(in_data.image_width);
    h_fl = floor_log2(in_data.image_height);
    w_p2 = ((in_data.image_width & (in_data.image_width - IN_W'(1))) == '0);
    h_p2 = ((in_data.image_height & (in_data.image_height - IN_W'(1))) == '0);
    w_z  = (in_data.image_width == '0);
    h_z  = (in_data.image_height == '0);
    down = size_mode_r[0] ||
           ((size_mode_r == MODE_COMPAT) &&
            ((in_data.image_width > IN_W'(COMPAT_SIDE)) ||
             (in_data.image_height > IN_W'(COMPAT_SIDE))));
    lim  = (size_mode_r == MODE_COMPAT) ? COMPAT_LOG2 : MAX_LOG2;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      w_fl_r <= w_fl;
      h_fl_r <= h_fl;
      w_p2_r <= w_p2;
      h_p2_r <= h_p2;
      w_z_r  <= w_z;
      h_z_r  <= h_z;
      down_r <= down;
      lim_r  <= lim;
    end
  end

  // stage 2: round down or round up, each with a clamp, as exponents
  always_comb begin
    w_cl = w_fl_r + {{(EXP_W-1){1'b0}}, !w_p2_r};
    h_cl = h_fl_r + {{(EXP_W-1){1'b0}}, !h_p2_r};
    if (down_r) begin
      ew2 = (w_fl_r > COMPAT_LOG2) ? COMPAT_LOG2 : w_fl_r;
      eh2 = (h_fl_r > COMPAT_LOG2) ? COMPAT_LOG2 : h_fl_r;
      zw2 = w_z_r;
      zh2 = h_z_r;
    end else begin
      ew2 = (w_cl > lim_r) ? lim_r : w_cl;
      eh2 = (h_cl > lim_r) ? lim_r : h_cl;
      zw2 = 1'b0;
      zh2 = 1'b0;
    end
    small2 = down_r && (w_z_r || h_z_r);
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      ew2_r    <= ew2;
      eh2_r    <= eh2;
      zw2_r    <= zw2;
      zh2_r    <= zh2;
      small2_r <= small2;
    end
  end

  // stage 3: aspect limit at 8:1, aspect code and lod
  always_comb begin
    w_ge  = zh2_r || (!zw2_r && (ew2_r >= eh2_r));
    emx   = w_ge ? ew2_r : eh2_r;
    zmx   = w_ge ? zw2_r : zh2_r;
    emn   = w_ge ? eh2_r : ew2_r;
    zmn   = w_ge ? zh2_r : zw2_r;
    diff  = emx - emn;
    // a zero short side sits one halving below a long side of one
    clip  = !zmx && (zmn ? (emx >= EXP_W'(3)) : (diff >= EXP_W'(4)));
    // smaller side becomes the larger one shifted right by three
    e_cut = (emx >= EXP_W'(3)) ? (emx - EXP_W'(3)) : '0;
    z_cut = (emx < EXP_W'(3));
    ew3   = ew2_r;
    eh3   = eh2_r;
    zw3   = zw2_r;
    zh3   = zh2_r;
    if (clip) begin
      asp = ASP_W'(3);
      if (w_ge) begin
        eh3 = e_cut;
        zh3 = z_cut;
      end else begin
        ew3 = e_cut;
        zw3 = z_cut;
      end
    end else if (zmx) begin
      asp = '0;
    end else if (zmn) begin
      asp = ASP_W'(emx) + ASP_W'(1);
    end else begin
      asp = ASP_W'(diff);
    end
    if (!w_ge) begin
      asp = asp + ASP_W'(4);
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      ew3_r    <= ew3;
      eh3_r    <= eh3;
      zw3_r    <= zw3;
      zh3_r    <= zh3;
      asp_r    <= asp;
      lod_r    <= zmx ? '0 : LOD_W'(emx);
      small3_r <= small2_r;
    end
  end

  // stage 4: decode exponents into sides and area
  always_comb begin
    res.block_width  = zw3_r ? '0 : (SIDE_W'(1) << ew3_r);
    res.block_height = zh3_r ? '0 : (SIDE_W'(1) << eh3_r);
    res.lod_log2     = lod_r;
    res.aspect_index = asp_r;
    res.block_area   = (zw3_r || zh3_r) ? '0 :
                       (AREA_W'(1) << ({1'b0, ew3_r} + {1'b0, eh3_r}));
    res.too_small    = small3_r;
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      out_r <= res;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

endmodule
